### rtl/core/ruyv_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and pixel widening functions for the RGB to UYVY
// pair converter. No dependencies.
package ruyv_pkg;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SOURCE_FORMAT = 1'b0,
    CFG_WIRE_FORMAT   = 1'b1
  } ruyv_cfg_idx_t;

  // Source pixel encodings
  localparam logic SRC_RGB565 = 1'b0;
  localparam logic SRC_BGR24  = 1'b1;

  // Wire formats
  localparam logic WIRE_UYVY  = 1'b0;
  localparam logic WIRE_BGR24 = 1'b1;

  // Valid byte counts of a result
  localparam logic [2:0] CNT_BGR_SINGLE = 3'd3;
  localparam logic [2:0] CNT_UYVY       = 3'd4;
  localparam logic [2:0] CNT_BGR_PAIR   = 3'd6;

  // BT.601 luma weights and scale factors
  localparam logic [15:0] KR = 16'd77;
  localparam logic [15:0] KG = 16'd150;
  localparam logic [15:0] KB = 16'd29;
  localparam logic [15:0] Y_SCALE = 16'd219;
  localparam logic signed [16:0] U_SCALE = 17'sd126;
  localparam logic signed [16:0] V_SCALE = 17'sd160;
  localparam logic [7:0] Y_OFFSET = 8'd16;
  localparam logic [7:0] C_OFFSET = 8'd128;

  // Per-stage advance enables shared by both lanes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } ruyv_adv_t;

  // What one lane delivers at the end of its pipeline
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
  } ruyv_lane_out_t;

  // floor(c * 255 / 31) = 8c + floor(7c / 31); 7c / 31 via reciprocal 265 / 2^13
  function automatic logic [7:0] widen5(input logic [4:0] c);
    logic [7:0]  c7;
    logic [15:0] p;
    c7 = {c, 3'b000} - {3'b000, c};
    p  = {8'd0, c7} * 16'd265;
    return {c, 3'b000} + {5'd0, p[15:13]};
  endfunction

  // floor(c * 255 / 63) = 4c + floor(c / 21)
  function automatic logic [7:0] widen6(input logic [5:0] c);
    logic [1:0] q;
    if (c >= 6'd63) begin
      q = 2'd3;
    end else if (c >= 6'd42) begin
      q = 2'd2;
    end else if (c >= 6'd21) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    return {c, 2'b00} + {6'd0, q};
  endfunction

endpackage

### rtl/core/ruyv_in_if.sv
`timescale 1ns / 1ps
// Input channel of the converter: one pixel pair per transfer.
// Depends on nothing.
interface ruyv_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_a;
  logic [23:0] pixel_b;
  logic        has_second;

  modport source (output valid, output pixel_a, output pixel_b, output has_second,
                  input ready);
  modport sink   (input valid, input pixel_a, input pixel_b, input has_second,
                  output ready);
endinterface

### rtl/core/ruyv_out_if.sv
`timescale 1ns / 1ps
// Result channel of the converter: up to six wire bytes per transfer.
// Depends on nothing.
interface ruyv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [7:0] byte4;
  logic [7:0] byte5;
  logic [2:0] byte_count;

  modport source (output valid, output byte0, output byte1, output byte2,
                  output byte3, output byte4, output byte5, output byte_count,
                  input ready);
  modport sink   (input valid, input byte0, input byte1, input byte2,
                  input byte3, input byte4, input byte5, input byte_count,
                  output ready);
endinterface

### rtl/core/ruyv_lane.sv
`timescale 1ns / 1ps
// One pixel lane: widen to 8-bit R,G,B, then luma and chroma in four stages.
// Depends on ruyv_pkg; the top level owns the valid bits and stage enables.
module ruyv_lane
  import ruyv_pkg::*;
(
  input  logic           clk,
  input  logic           src_fmt,
  input  ruyv_adv_t      adv,
  input  logic [23:0]    pixel,
  output ruyv_lane_out_t result
);

  // stage 1: widened color
  logic [7:0] r1_r, g1_r, b1_r;
  logic [7:0] r1_nxt, g1_nxt, b1_nxt;
  // stage 2: luma index
  logic [7:0] r2_r, g2_r, b2_r, y2_r;
  logic [15:0] ysum;
  // stage 3: scaled products
  logic [7:0] r3_r, g3_r, b3_r;
  logic [15:0] yp3_r;
  logic signed [16:0] du3_r, dv3_r;
  logic signed [8:0] db, dr;
  logic signed [16:0] du_nxt, dv_nxt;
  // stage 4: Y, U, V bytes
  logic [7:0] r4_r, g4_r, b4_r, y4_r, u4_r, v4_r;
  logic [15:0] yq;

  always_comb begin
    if (src_fmt == SRC_BGR24) begin
      r1_nxt = pixel[23:16];
      g1_nxt = pixel[15:8];
      b1_nxt = pixel[7:0];
    end else begin
      r1_nxt = widen5(pixel[15:11]);
      g1_nxt = widen6(pixel[10:5]);
      b1_nxt = widen5(pixel[4:0]);
    end
  end

  assign ysum = KR * {8'd0, r1_r} + KG * {8'd0, g1_r} + KB * {8'd0, b1_r};

  assign db = $signed({1'b0, b2_r}) - $signed({1'b0, y2_r});
  assign dr = $signed({1'b0, r2_r}) - $signed({1'b0, y2_r});
  assign du_nxt = $signed({{8{db[8]}}, db}) * U_SCALE;
  assign dv_nxt = $signed({{8{dr[8]}}, dr}) * V_SCALE;

  // x / 255 for x below 65535: (x + (x >> 8) + 1) >> 8
  assign yq = yp3_r + {8'd0, yp3_r[15:8]} + 16'd1;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      r1_r <= r1_nxt;
      g1_r <= g1_nxt;
      b1_r <= b1_nxt;
    end
    if (adv.s2) begin
      r2_r <= r1_r;
      g2_r <= g1_r;
      b2_r <= b1_r;
      y2_r <= ysum[15:8];
    end
    if (adv.s3) begin
      r3_r  <= r2_r;
      g3_r  <= g2_r;
      b3_r  <= b2_r;
      yp3_r <= {8'd0, y2_r} * Y_SCALE;
      du3_r <= du_nxt;
      dv3_r <= dv_nxt;
    end
    if (adv.s4) begin
      r4_r <= r3_r;
      g4_r <= g3_r;
      b4_r <= b3_r;
      y4_r <= Y_OFFSET + yq[15:8];
      // floor shift by 8, then wrap to a byte
      u4_r <= C_OFFSET + du3_r[15:8];
      v4_r <= C_OFFSET + dv3_r[15:8];
    end
  end

  assign result = '{r: r4_r, g: g4_r, b: b4_r, y: y4_r, u: u4_r, v: v4_r};

endmodule

### rtl/core/rgb_to_uyvy_pair_converter.sv
`timescale 1ns / 1ps
// Top level of the RGB to UYVY pair converter: config registers, valid
// pipeline, two ruyv_lane instances and the output register. Uses ruyv_pkg.
//
//  channel  | direction | transfer carries
//  ---------+-----------+----------------------------------------------
//  in_ch    | sink      | pixel_a, pixel_b, has_second
//  out_ch   | source    | byte0..byte5, byte_count
//  cfg_*    | write     | cfg_index selects source_format / wire_format
//
// One pixel pair per cycle unless out_ch stalls; a transfer passes the four
// lane stages and then the output register on its way to out_ch.valid.
// rst_n is synchronous and clears the config registers and all valid bits.
// Each stage holds only while it is full and the stage after it holds, so a
// stalled output still lets empty stages upstream fill.
module rgb_to_uyvy_pair_converter
  import ruyv_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [0:0]    cfg_data,
  ruyv_in_if.sink       in_ch,
  ruyv_out_if.source    out_ch
);

  logic src_fmt_r, wire_fmt_r;

  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic hs1_r, hs2_r, hs3_r, hs4_r;
  logic en_out;
  ruyv_adv_t adv;

  ruyv_lane_out_t lane_a, lane_b;
  logic [23:0] pixel_b_eff;

  logic [8:0] usum, vsum;
  logic [7:0] b0_nxt, b1_nxt, b2_nxt, b3_nxt, b4_nxt, b5_nxt;
  logic [2:0] cnt_nxt;
  logic [7:0] b0_r, b1_r, b2_r, b3_r, b4_r, b5_r;
  logic [2:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r  <= SRC_RGB565;
      wire_fmt_r <= WIRE_UYVY;
    end else if (cfg_we) begin
      case (ruyv_cfg_idx_t'(cfg_index))
        CFG_SOURCE_FORMAT: src_fmt_r  <= cfg_data[0];
        CFG_WIRE_FORMAT:   wire_fmt_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // a stage advances when empty or when the next one advances
  assign en_out = !out_valid_r || out_ch.ready;
  assign adv.s4 = !v4_r || en_out;
  assign adv.s3 = !v3_r || adv.s4;
  assign adv.s2 = !v2_r || adv.s3;
  assign adv.s1 = !v1_r || adv.s2;
  assign in_ch.ready = adv.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv.s1) v1_r <= in_ch.valid;
      if (adv.s2) v2_r <= v1_r;
      if (adv.s3) v3_r <= v2_r;
      if (adv.s4) v4_r <= v3_r;
      if (en_out) out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) hs1_r <= in_ch.has_second;
    if (adv.s2) hs2_r <= hs1_r;
    if (adv.s3) hs3_r <= hs2_r;
    if (adv.s4) hs4_r <= hs3_r;
  end

  // a lone pixel stands in for its missing partner
  assign pixel_b_eff = in_ch.has_second ? in_ch.pixel_b : in_ch.pixel_a;

  ruyv_lane u_lane_a (
    .clk     (clk),
    .src_fmt (src_fmt_r),
    .adv     (adv),
    .pixel   (in_ch.pixel_a),
    .result  (lane_a)
  );

  ruyv_lane u_lane_b (
    .clk     (clk),
    .src_fmt (src_fmt_r),
    .adv     (adv),
    .pixel   (pixel_b_eff),
    .result  (lane_b)
  );

  assign usum = {1'b0, lane_a.u} + {1'b0, lane_b.u};
  assign vsum = {1'b0, lane_a.v} + {1'b0, lane_b.v};

  always_comb begin
    if (wire_fmt_r == WIRE_BGR24) begin
      b0_nxt = lane_a.b;
      b1_nxt = lane_a.g;
      b2_nxt = lane_a.r;
      if (hs4_r) begin
        b3_nxt  = lane_b.b;
        b4_nxt  = lane_b.g;
        b5_nxt  = lane_b.r;
        cnt_nxt = CNT_BGR_PAIR;
      end else begin
        b3_nxt  = 8'd0;
        b4_nxt  = 8'd0;
        b5_nxt  = 8'd0;
        cnt_nxt = CNT_BGR_SINGLE;
      end
    end else begin
      b0_nxt  = usum[8:1];
      b1_nxt  = lane_a.y;
      b2_nxt  = vsum[8:1];
      b3_nxt  = lane_b.y;
      b4_nxt  = 8'd0;
      b5_nxt  = 8'd0;
      cnt_nxt = CNT_UYVY;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      b0_r  <= b0_nxt;
      b1_r  <= b1_nxt;
      b2_r  <= b2_nxt;
      b3_r  <= b3_nxt;
      b4_r  <= b4_nxt;
      b5_r  <= b5_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.byte0      = b0_r;
  assign out_ch.byte1      = b1_r;
  assign out_ch.byte2      = b2_r;
  assign out_ch.byte3      = b3_r;
  assign out_ch.byte4      = b4_r;
  assign out_ch.byte5      = b5_r;
  assign out_ch.byte_count = cnt_r;

  // a full pipeline behind a stalled output must refuse input
  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && v4_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while pipeline full and output stalled");

  // an input transfer always lands in stage one
  a_input_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v1_r)
    else $error("input transfer dropped");

  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (cnt_r == CNT_BGR_SINGLE || cnt_r == CNT_UYVY ||
                     cnt_r == CNT_BGR_PAIR))
    else $error("illegal byte count");

  // only a full B,G,R pair fills the upper bytes
  a_upper_bytes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && cnt_r != CNT_BGR_PAIR) |-> (b4_r == 8'd0 && b5_r == 8'd0))
    else $error("upper bytes set without a B,G,R pair");

endmodule
